// File: design/gqg_pkg.sv
// Shared types, constants and helpers for the glyph quad generator.
package gqg_pkg;

	localparam int GLYPH_ENTRIES = 128;
	localparam int MAX_VERTICES  = 65536;
	localparam int GLYPH_AW      = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
	localparam int CNT_W         = 17;

	localparam logic [15:0]      SCALE_RESET = 16'h1000;
	localparam logic [31:0]      COLOR_RESET = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] CAP_RESET   = 17'h1_0000;

	// Item kinds carried on the mode field
	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_BEGIN = 2'd1,
		MODE_PEN   = 2'd2,
		MODE_CHAR  = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SCALE_X  = 2'd0,
		CFG_SCALE_Y  = 2'd1,
		CFG_COLOR    = 2'd2,
		CFG_CAPACITY = 2'd3
	} cfg_reg_t;

	// Texture rectangle of one glyph, Q0.16
	typedef struct packed {
		logic [15:0] u;
		logic [15:0] v;
		logic [15:0] w;
		logic [15:0] h;
	} tex_t;

	// Placement of one glyph, texture units
	typedef struct packed {
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic [15:0]        adv;
	} place_t;

	// Input transaction as seen by the pipeline
	typedef struct packed {
		mode_t              mode;
		logic [7:0]         char_code;
		tex_t               tex;
		place_t             place;
		logic               present;
		logic signed [15:0] pen_x;
		logic signed [15:0] pen_y;
	} item_t;

	// After table lookup
	typedef struct packed {
		mode_t              mode;
		logic               in_range;
		logic               present;
		tex_t               tex;
		place_t             place;
		logic signed [15:0] pen_x;
		logic signed [15:0] pen_y;
	} s1_t;

	// After scaling; sizes and offsets in Q4.12
	typedef struct packed {
		mode_t              mode;
		logic               in_range;
		logic               present;
		logic               size_zero;
		logic signed [15:0] pen_x;
		logic signed [15:0] pen_y;
		logic [15:0]        size_x;
		logic [15:0]        size_y;
		logic signed [16:0] off_x;
		logic signed [16:0] off_y;
		logic [15:0]        adv;
		logic [15:0]        u0;
		logic [15:0]        u1;
		logic [15:0]        v0;
		logic [15:0]        v1;
	} s2_t;

	// Clamp to signed 16 bits
	function automatic logic signed [15:0] sat_s16(input logic signed [18:0] x);
		if (x > 19'sd32767) begin
			return 16'sh7FFF;
		end else if (x < -19'sd32768) begin
			return 16'sh8000;
		end
		return x[15:0];
	endfunction

	// Clamp to unsigned 16 bits
	function automatic logic [15:0] sat_u16(input logic [16:0] x);
		return x[16] ? 16'hFFFF : x[15:0];
	endfunction

endpackage

// File: design/glyph_quad_generator.sv
// Glyph quad generator top level: configuration registers and pipeline.
//
// Usage: input transactions (in_valid/in_stall) carry one of four kinds:
// a glyph table load, a batch begin, a pen set, or a character. Each
// drawn character yields four vertex transactions on the output channel
// (out_valid/out_stall), one per cycle unless stalled; last flags the fourth.
// Configuration goes through cfg_valid/cfg_ready with a register index and
// data; cfg_ready is always high. Write configuration only while idle.
// A character accepted on the input passes the table read, scaling multiply
// and quad registers before its first vertex shows. A drawn character holds
// the single-vertex output port for its four vertices; the next one waits
// until the last corner is taken, while other transactions, dropped characters
// included, do not wait for the quad register. Reset clears all glyph present
// bits at once, the pen and vertex count to zero and the registers to their
// defaults; no sweep. When the receiver stalls, the current vertex holds and up
// to two more transactions queue in the pipeline before in_stall rises.
module glyph_quad_generator (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [7:0]         char_code,
	input  logic [15:0]        glyph_u,
	input  logic [15:0]        glyph_v,
	input  logic [15:0]        glyph_w,
	input  logic [15:0]        glyph_h,
	input  logic signed [15:0] glyph_off_x,
	input  logic signed [15:0] glyph_off_y,
	input  logic [15:0]        glyph_advance,
	input  logic               glyph_present,
	input  logic signed [15:0] pen_x_in,
	input  logic signed [15:0] pen_y_in,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] vertex_x,
	output logic signed [15:0] vertex_y,
	output logic [15:0]        tex_u,
	output logic [15:0]        tex_v,
	output logic [31:0]        vertex_color,
	output logic [15:0]        vertex_index,
	output logic               last,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import gqg_pkg::*;

	logic [15:0]      scale_x_q;
	logic [15:0]      scale_y_q;
	logic [31:0]      color_q;
	logic [CNT_W-1:0] cap_q;

	item_t            item;
	logic             tbl_ready;
	logic             s1_valid;
	logic             s1_ready;
	s1_t              s1;
	logic             s2_valid;
	logic             s2_ready;
	s2_t              s2;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
			color_q   <= COLOR_RESET;
			cap_q     <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SCALE_X:  scale_x_q <= cfg_data[15:0];
				CFG_SCALE_Y:  scale_y_q <= cfg_data[15:0];
				CFG_COLOR:    color_q   <= cfg_data;
				CFG_CAPACITY: cap_q     <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input transaction
	assign item.mode          = mode_t'(mode);
	assign item.char_code     = char_code;
	assign item.tex.u         = glyph_u;
	assign item.tex.v         = glyph_v;
	assign item.tex.w         = glyph_w;
	assign item.tex.h         = glyph_h;
	assign item.place.off_x   = glyph_off_x;
	assign item.place.off_y   = glyph_off_y;
	assign item.place.adv     = glyph_advance;
	assign item.present       = glyph_present;
	assign item.pen_x         = pen_x_in;
	assign item.pen_y         = pen_y_in;

	assign in_stall = !tbl_ready;

	gqg_glyph_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (tbl_ready),
		.item     (item),
		.dn_valid (s1_valid),
		.dn_ready (s1_ready),
		.s1       (s1)
	);

	gqg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s1_ready),
		.s1       (s1),
		.scale_x  (scale_x_q),
		.scale_y  (scale_y_q),
		.dn_valid (s2_valid),
		.dn_ready (s2_ready),
		.s2       (s2)
	);

	gqg_layout u_layout (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (s2_valid),
		.up_ready        (s2_ready),
		.s2              (s2),
		.vertex_capacity (cap_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vertex_x        (vertex_x),
		.vertex_y        (vertex_y),
		.tex_u           (tex_u),
		.tex_v           (tex_v),
		.vertex_index    (vertex_index),
		.last            (last)
	);

	assign vertex_color = color_q;

endmodule

// File: design/gqg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gqg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/gqg_glyph_table.sv
// Glyph table: texture and placement RAMs, present bits, first pipeline stage.
module gqg_glyph_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  gqg_pkg::item_t item,
	output logic           dn_valid,
	input  logic           dn_ready,
	output gqg_pkg::s1_t   s1
);
	import gqg_pkg::*;

	logic                     acc;
	logic                     in_range;
	logic                     load_wr;
	logic [GLYPH_AW-1:0]      idx;
	logic [GLYPH_ENTRIES-1:0] present_q;
	logic                     present_rd;
	tex_t                     tex_rd;
	place_t                   place_rd;

	logic                     v_s1;
	mode_t                    mode_s1;
	logic                     in_range_s1;
	logic                     present_s1;
	logic signed [15:0]       pen_x_s1;
	logic signed [15:0]       pen_y_s1;

	assign up_ready = !v_s1 || dn_ready;
	assign acc      = up_valid && up_ready;
	assign in_range = {1'b0, item.char_code} < 9'(GLYPH_ENTRIES);
	assign idx      = item.char_code[GLYPH_AW-1:0];
	assign load_wr  = acc && (item.mode == MODE_LOAD) && in_range;

	// Present bits live in flops so reset clears the whole table at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (load_wr) begin
			present_q[idx] <= item.present;
		end
	end

	assign present_rd = in_range && present_q[idx];

	gqg_ram #(
		.WIDTH ($bits(tex_t)),
		.DEPTH (GLYPH_ENTRIES)
	) u_tex_ram (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (idx),
		.wr_data (item.tex),
		.rd_en   (acc),
		.rd_addr (idx),
		.rd_data (tex_rd)
	);

	gqg_ram #(
		.WIDTH ($bits(place_t)),
		.DEPTH (GLYPH_ENTRIES)
	) u_place_ram (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (idx),
		.wr_data (item.place),
		.rd_en   (acc),
		.rd_addr (idx),
		.rd_data (place_rd)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_ready) begin
			v_s1 <= up_valid;
		end
	end

	// Stage 1 payload, captured alongside the RAM read
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1     <= item.mode;
			in_range_s1 <= in_range;
			present_s1  <= present_rd;
			pen_x_s1    <= item.pen_x;
			pen_y_s1    <= item.pen_y;
		end
	end

	assign dn_valid    = v_s1;
	assign s1.mode     = mode_s1;
	assign s1.in_range = in_range_s1;
	assign s1.present  = present_s1;
	assign s1.tex      = tex_rd;
	assign s1.place    = place_rd;
	assign s1.pen_x    = pen_x_s1;
	assign s1.pen_y    = pen_y_s1;

	// A load in range leaves the present bit as written
	a_present_written: assert property (@(posedge clk) disable iff (!arst_n)
		load_wr |=> present_q[$past(idx)] == $past(item.present))
		else $error("present bit not updated by glyph load");

endmodule

// File: design/gqg_scale.sv
// Scaling stage: glyph size, offset and advance times the screen scale.
module gqg_scale (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  gqg_pkg::s1_t s1,
	input  logic [15:0]  scale_x,
	input  logic [15:0]  scale_y,
	output logic         dn_valid,
	input  logic         dn_ready,
	output gqg_pkg::s2_t s2
);
	import gqg_pkg::*;

	logic               acc;
	logic [31:0]        prod_w;
	logic [31:0]        prod_h;
	logic [31:0]        prod_adv;
	logic signed [32:0] prod_ox;
	logic signed [32:0] prod_oy;
	s2_t                nxt;
	logic               v_s2;
	s2_t                data_s2;

	assign up_ready = !v_s2 || dn_ready;
	assign acc      = up_valid && up_ready;

	// One multiplier per quantity; Q0.16 times Q4.12, floor back to Q4.12
	assign prod_w   = 32'(s1.tex.w) * 32'(scale_x);
	assign prod_h   = 32'(s1.tex.h) * 32'(scale_y);
	assign prod_adv = 32'(s1.place.adv) * 32'(scale_x);
	assign prod_ox  = 33'($signed(s1.place.off_x)) * 33'($signed({1'b0, scale_x}));
	assign prod_oy  = 33'($signed(s1.place.off_y)) * 33'($signed({1'b0, scale_y}));

	always_comb begin
		nxt           = '0;
		nxt.mode      = s1.mode;
		nxt.in_range  = s1.in_range;
		nxt.present   = s1.present;
		nxt.size_zero = (s1.tex.w == 16'd0) || (s1.tex.h == 16'd0);
		nxt.pen_x     = s1.pen_x;
		nxt.pen_y     = s1.pen_y;
		nxt.size_x    = prod_w[31:16];
		nxt.size_y    = prod_h[31:16];
		nxt.off_x     = prod_ox[32:16];
		nxt.off_y     = prod_oy[32:16];
		nxt.adv       = prod_adv[31:16];
		// texture corners
		nxt.u0        = s1.tex.u;
		nxt.u1        = sat_u16({1'b0, s1.tex.u} + {1'b0, s1.tex.w});
		nxt.v0        = s1.tex.v;
		nxt.v1        = sat_u16({1'b0, s1.tex.v} + {1'b0, s1.tex.h});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (up_ready) begin
			v_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_s2 <= nxt;
		end
	end

	assign dn_valid = v_s2;
	assign s2       = data_s2;

endmodule

// File: design/gqg_layout.sv
// Layout stage: pen and vertex count state, quad register, corner sequencer.
module gqg_layout (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  gqg_pkg::s2_t                  s2,
	input  logic [gqg_pkg::CNT_W-1:0]     vertex_capacity,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            vertex_x,
	output logic signed [15:0]            vertex_y,
	output logic [15:0]                   tex_u,
	output logic [15:0]                   tex_v,
	output logic [15:0]                   vertex_index,
	output logic                          last
);
	import gqg_pkg::*;

	localparam logic [1:0] CORNER_FIRST  = 2'd0;
	localparam logic [1:0] CORNER_SECOND = 2'd1;
	localparam logic [1:0] CORNER_THIRD  = 2'd2;
	localparam logic [1:0] CORNER_LAST   = 2'd3;

	logic signed [15:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [CNT_W-1:0]   cap;
	logic               fits;
	logic               glyph_ok;
	logic               emit;
	logic               take;
	logic               quad_load;
	logic               out_acc;
	logic               quad_free;

	logic signed [17:0] pen_sum;
	logic signed [18:0] bx;
	logic signed [18:0] by;
	logic signed [18:0] sx_e;
	logic signed [18:0] sy_e;

	logic               quad_v_q;
	logic [1:0]         corner_q;
	logic signed [15:0] xa_q, xb_q, ya_q, yb_q;
	logic [15:0]        ua_q, ub_q, va_q, vb_q;
	logic [15:0]        base_q;

	// Drop decision for a character
	assign cap      = (vertex_capacity < CNT_W'(MAX_VERTICES)) ?
	                  vertex_capacity : CNT_W'(MAX_VERTICES);
	assign fits     = ({1'b0, cnt_q} + (CNT_W+1)'(4)) <= {1'b0, cap};
	assign glyph_ok = (s2.mode == MODE_CHAR) && s2.in_range && s2.present && fits;
	assign emit     = glyph_ok && !s2.size_zero;

	// Handshake between the state stage and the quad register
	assign out_acc   = quad_v_q && !out_stall;
	assign quad_free = !quad_v_q || (out_acc && (corner_q == CORNER_LAST));
	assign up_ready  = !emit || quad_free;
	assign take      = up_valid && up_ready;
	assign quad_load = take && emit;

	// Position arithmetic
	assign pen_sum = 18'(pen_x_q) + $signed({2'b00, s2.adv});
	assign bx      = 19'(pen_x_q) + 19'($signed(s2.off_x));
	assign by      = 19'(pen_y_q) + 19'($signed(s2.off_y));
	assign sx_e    = {3'b000, s2.size_x};
	assign sy_e    = {3'b000, s2.size_y};

	// Pen and vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			case (s2.mode)
				MODE_LOAD: begin
				end
				MODE_BEGIN: begin
					cnt_q <= '0;
				end
				MODE_PEN: begin
					pen_x_q <= s2.pen_x;
					pen_y_q <= s2.pen_y;
				end
				MODE_CHAR: begin
					if (glyph_ok) begin
						pen_x_q <= sat_s16(19'(pen_sum));
					end
					if (emit) begin
						cnt_q <= cnt_q + CNT_W'(4);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Quad register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_v_q <= 1'b0;
			corner_q <= CORNER_FIRST;
		end else if (quad_load) begin
			quad_v_q <= 1'b1;
			corner_q <= CORNER_FIRST;
		end else if (out_acc) begin
			if (corner_q == CORNER_LAST) begin
				quad_v_q <= 1'b0;
			end
			corner_q <= corner_q + 2'd1;
		end
	end

	// Quad payload
	always_ff @(posedge clk) begin
		if (quad_load) begin
			xa_q   <= sat_s16(bx);
			xb_q   <= sat_s16(bx + sx_e);
			ya_q   <= sat_s16(by - sy_e);
			yb_q   <= sat_s16(by);
			ua_q   <= s2.u0;
			ub_q   <= s2.u1;
			va_q   <= s2.v0;
			vb_q   <= s2.v1;
			base_q <= cnt_q[15:0];
		end
	end

	// Corner select
	always_comb begin
		case (corner_q)
			CORNER_FIRST: begin
				vertex_x = xa_q; vertex_y = ya_q; tex_u = ua_q; tex_v = va_q;
			end
			CORNER_SECOND: begin
				vertex_x = xb_q; vertex_y = ya_q; tex_u = ub_q; tex_v = va_q;
			end
			CORNER_THIRD: begin
				vertex_x = xb_q; vertex_y = yb_q; tex_u = ub_q; tex_v = vb_q;
			end
			CORNER_LAST: begin
				vertex_x = xa_q; vertex_y = yb_q; tex_u = ua_q; tex_v = vb_q;
			end
			default: begin
				vertex_x = xa_q; vertex_y = ya_q; tex_u = ua_q; tex_v = va_q;
			end
		endcase
	end

	assign out_valid    = quad_v_q;
	assign vertex_index = base_q + 16'(corner_q);
	assign last         = (corner_q == CORNER_LAST);

	// Count never passes the largest buffer
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond buffer size");

	// A new quad starts at its first corner and books four vertices
	a_quad_start: assert property (@(posedge clk) disable iff (!arst_n)
		quad_load |=> quad_v_q && (corner_q == CORNER_FIRST) &&
		              (cnt_q == $past(cnt_q) + CNT_W'(4)))
		else $error("quad start out of order");

	// Last corner taken with nothing behind it empties the quad register
	a_quad_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && (corner_q == CORNER_LAST) && !quad_load) |=> !quad_v_q)
		else $error("quad register not released after last corner");

endmodule
